FILE: design/console_cpu_bus_with_sprite_dma_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the console CPU bus block
// Shared forms for concurrent checks, with and without a reset disable.
// ---------------------------------------------------------------------------
`ifndef CONSOLE_CPU_BUS_WITH_SPRITE_DMA_TOP_MACROS_SVH
`define CONSOLE_CPU_BUS_WITH_SPRITE_DMA_TOP_MACROS_SVH

// check that is off while reset is high
`define CCBSD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define CCBSD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ccbsd_pkg.sv
// ---------------------------------------------------------------------------
// ccbsd_pkg
// Types, codes, address map and helpers of the console CPU bus block.
// ---------------------------------------------------------------------------
package ccbsd_pkg;

   localparam int RAM_BYTES_DEF     = 2048;
   localparam int PROGRAM_BYTES_DEF = 16384;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic [15:0] ADDR_RAM_END  = 16'h1FFF;
   localparam logic [15:0] ADDR_PPU_END  = 16'h3FFF;
   localparam logic [15:0] ADDR_DMA_PAGE = 16'h4014;
   localparam logic [15:0] ADDR_PAD0     = 16'h4016;
   localparam logic [15:0] ADDR_PAD1     = 16'h4017;
   localparam logic [15:0] ADDR_PROG     = 16'h8000;

   localparam logic [2:0] PHASE_SLOT_A = 3'd0;
   localparam logic [2:0] PHASE_SLOT_B = 3'd3;
   localparam logic [2:0] PHASE_LAST   = 3'd5;

   localparam logic [7:0] DMA_LAST_INDEX = 8'hFF;

   // conditional subtract steps; covers value / modulus below 64
   localparam int FOLD_STEPS = 6;

   typedef enum logic [2:0] {
      REGION_NONE,
      REGION_RAM,
      REGION_PPU,
      REGION_DMA,
      REGION_PAD,
      REGION_PROG
   } region_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  ppu_read_data;
      logic [7:0]  controller_buttons;
      logic        ppu_nmi;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       ppu_access;
      logic       ppu_write;
      logic [2:0] ppu_register;
      logic       oam_write;
      logic [7:0] oam_index;
      logic [7:0] oam_data;
      logic       cpu_step;
      logic       cpu_nmi;
      logic       dma_busy;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   function automatic region_type decode_region(logic [15:0] addr);
      region_type r;
      if (addr <= ADDR_RAM_END) begin
         r = REGION_RAM;
      end else if (addr <= ADDR_PPU_END) begin
         r = REGION_PPU;
      end else if (addr == ADDR_DMA_PAGE) begin
         r = REGION_DMA;
      end else if (addr == ADDR_PAD0 || addr == ADDR_PAD1) begin
         r = REGION_PAD;
      end else if (addr >= ADDR_PROG) begin
         r = REGION_PROG;
      end else begin
         r = REGION_NONE;
      end
      return r;
   endfunction

   // remainder by long division with a fixed number of compare/subtract steps
   function automatic logic [15:0] fold_mod(logic [15:0] value, int unsigned modulus);
      logic [15:0] rem;
      logic [31:0] part;
      rem = value;
      for (int j = FOLD_STEPS - 1; j >= 0; j--) begin
         part = 32'(modulus) << j;
         if ({16'h0000, rem} >= part) begin
            rem = rem - part[15:0];
         end
      end
      return rem;
   endfunction

endpackage

FILE: design/ccbsd_if.sv
// ---------------------------------------------------------------------------
// ccbsd_req_if / ccbsd_rsp_if
// Valid/ready channels for bus items and their results.
// ---------------------------------------------------------------------------
interface ccbsd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [7:0]  ppu_read_data;
   logic [7:0]  controller_buttons;
   logic        ppu_nmi;

   modport source (
      output valid, mode, address, write_data, ppu_read_data, controller_buttons, ppu_nmi,
      input  ready
   );
   modport sink (
      input  valid, mode, address, write_data, ppu_read_data, controller_buttons, ppu_nmi,
      output ready
   );
endinterface

interface ccbsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       ppu_access;
   logic       ppu_write;
   logic [2:0] ppu_register;
   logic       oam_write;
   logic [7:0] oam_index;
   logic [7:0] oam_data;
   logic       cpu_step;
   logic       cpu_nmi;
   logic       dma_busy;

   modport source (
      output valid, read_data, ppu_access, ppu_write, ppu_register, oam_write, oam_index,
             oam_data, cpu_step, cpu_nmi, dma_busy,
      input  ready
   );
   modport sink (
      input  valid, read_data, ppu_access, ppu_write, ppu_register, oam_write, oam_index,
             oam_data, cpu_step, cpu_nmi, dma_busy,
      output ready
   );
endinterface

FILE: design/ccbsd_ctrl.sv
// ---------------------------------------------------------------------------
// ccbsd_ctrl
// Item sequencer: capture, commit into the output register, result valid.
// ---------------------------------------------------------------------------
module ccbsd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ccbsd_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      req_ready   = (state_ff == S_IDLE);
      cmd.capture = req_valid && req_ready;
      cmd.commit  = (state_ff == S_EXEC) && out_free;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/ccbsd_datapath.sv
// ---------------------------------------------------------------------------
// ccbsd_datapath
// Address decode, work RAM, program store, pads, sprite DMA and tick phase.
// ---------------------------------------------------------------------------
module ccbsd_datapath #(
   parameter int RAM_BYTES     = ccbsd_pkg::RAM_BYTES_DEF,
   parameter int PROGRAM_BYTES = ccbsd_pkg::PROGRAM_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ccbsd_pkg::ctrl_cmd_type     cmd,
   input  ccbsd_pkg::req_payload_type  req,
   output ccbsd_pkg::rsp_payload_type  rsp
);

   localparam int RAM_AW  = $clog2(RAM_BYTES);
   localparam int PROG_AW = $clog2(PROGRAM_BYTES);

   logic [7:0] work_ram      [RAM_BYTES];
   logic [7:0] program_store [PROGRAM_BYTES];

   // captured item
   logic [1:0]         mode_ff;
   logic [15:0]        addr_ff;
   logic [7:0]         wdata_ff;
   logic [7:0]         pdata_ff;
   logic [7:0]         buttons_ff;
   logic               nmi_ff;
   logic [RAM_AW-1:0]  ram_idx_ff;
   logic [PROG_AW-1:0] prog_idx_ff;
   logic [7:0]         ram_q_ff;
   logic [7:0]         prog_q_ff;

   // block state
   logic [1:0][7:0] pad_ff, pad_in;
   logic [7:0]      page_ff, page_in;
   logic [7:0]      index_ff, index_in;
   logic [7:0]      byte_ff, byte_in;
   logic            running_ff, running_in;
   logic            align_ff, align_in;
   logic [2:0]      phase_ff, phase_in;

   ccbsd_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [15:0]           eff_addr_in;
   logic [15:0]           ram_fold;
   logic [15:0]           prog_fold;
   logic [RAM_AW-1:0]     ram_idx_in;
   logic [PROG_AW-1:0]    prog_idx_in;
   ccbsd_pkg::region_type region;
   logic                  slot, is_tick, dma_move, bus_rd, oam_wr, pad_sel;
   logic                  ram_we, prog_we;
   logic [7:0]            rd_byte;

   // capture side: DMA source address on ticks, bus address otherwise
   always_comb begin
      eff_addr_in = (req.mode == ccbsd_pkg::MODE_TICK) ? {page_ff, index_ff} : req.address;
      ram_fold    = ccbsd_pkg::fold_mod({3'b000, eff_addr_in[12:0]}, RAM_BYTES);
      prog_fold   = ccbsd_pkg::fold_mod({1'b0, eff_addr_in[14:0]}, PROGRAM_BYTES);
      ram_idx_in  = ram_fold[RAM_AW-1:0];
      prog_idx_in = prog_fold[PROG_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req.mode;
         addr_ff     <= eff_addr_in;
         wdata_ff    <= req.write_data;
         pdata_ff    <= req.ppu_read_data;
         buttons_ff  <= req.controller_buttons;
         nmi_ff      <= req.ppu_nmi;
         ram_idx_ff  <= ram_idx_in;
         prog_idx_ff <= prog_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) work_ram[ram_idx_ff] <= wdata_ff;
      if (cmd.capture) ram_q_ff <= work_ram[ram_idx_in];
   end

   always_ff @(posedge clock) begin
      if (prog_we) program_store[prog_idx_ff] <= wdata_ff;
      if (cmd.capture) prog_q_ff <= program_store[prog_idx_in];
   end

   // commit side
   always_comb begin
      region   = ccbsd_pkg::decode_region(addr_ff);
      slot     = (phase_ff == ccbsd_pkg::PHASE_SLOT_A) || (phase_ff == ccbsd_pkg::PHASE_SLOT_B);
      is_tick  = (mode_ff == ccbsd_pkg::MODE_TICK);
      dma_move = is_tick && slot && running_ff && !align_ff;
      bus_rd   = (mode_ff == ccbsd_pkg::MODE_READ)
                 || (dma_move && phase_ff == ccbsd_pkg::PHASE_SLOT_A);
      oam_wr   = dma_move && (phase_ff == ccbsd_pkg::PHASE_SLOT_B);
      pad_sel  = addr_ff[0];
      ram_we   = cmd.commit && (mode_ff == ccbsd_pkg::MODE_WRITE)
                 && (region == ccbsd_pkg::REGION_RAM);
      prog_we  = cmd.commit && (mode_ff == ccbsd_pkg::MODE_WRITE)
                 && (region == ccbsd_pkg::REGION_PROG);

      case (region)
         ccbsd_pkg::REGION_RAM:  rd_byte = ram_q_ff;
         ccbsd_pkg::REGION_PPU:  rd_byte = pdata_ff;
         ccbsd_pkg::REGION_PAD:  rd_byte = {7'b0000000, pad_ff[pad_sel][7]};
         ccbsd_pkg::REGION_PROG: rd_byte = prog_q_ff;
         default:                rd_byte = 8'h00;
      endcase

      pad_in     = pad_ff;
      page_in    = page_ff;
      index_in   = index_ff;
      byte_in    = byte_ff;
      running_in = running_ff;
      align_in   = align_ff;
      phase_in   = phase_ff;
      rsp_in     = '0;

      if (bus_rd && region == ccbsd_pkg::REGION_PPU) begin
         rsp_in.ppu_access   = 1'b1;
         rsp_in.ppu_register = addr_ff[2:0];
      end
      if (bus_rd && region == ccbsd_pkg::REGION_PAD) begin
         pad_in[pad_sel] = {pad_ff[pad_sel][6:0], 1'b0};
      end
      if (mode_ff == ccbsd_pkg::MODE_READ) begin
         rsp_in.read_data = rd_byte;
      end

      if (mode_ff == ccbsd_pkg::MODE_WRITE) begin
         case (region)
            ccbsd_pkg::REGION_PPU: begin
               rsp_in.ppu_access   = 1'b1;
               rsp_in.ppu_write    = 1'b1;
               rsp_in.ppu_register = addr_ff[2:0];
            end
            ccbsd_pkg::REGION_DMA: begin
               page_in    = wdata_ff;
               index_in   = 8'h00;
               running_in = 1'b1;
            end
            ccbsd_pkg::REGION_PAD: begin
               pad_in[pad_sel] = buttons_ff;
            end
            default: begin
            end
         endcase
      end

      if (is_tick) begin
         phase_in       = (phase_ff == ccbsd_pkg::PHASE_LAST) ? 3'd0 : phase_ff + 3'd1;
         rsp_in.cpu_nmi = nmi_ff;
         if (slot && !running_ff) rsp_in.cpu_step = 1'b1;
         if (slot && running_ff && align_ff && phase_ff == ccbsd_pkg::PHASE_SLOT_B) begin
            align_in = 1'b0;
         end
         if (dma_move && phase_ff == ccbsd_pkg::PHASE_SLOT_A) byte_in = rd_byte;
         if (oam_wr) begin
            rsp_in.oam_write = 1'b1;
            rsp_in.oam_index = index_ff;
            rsp_in.oam_data  = byte_ff;
            index_in         = index_ff + 8'd1;
            if (index_ff == ccbsd_pkg::DMA_LAST_INDEX) begin
               running_in = 1'b0;
               align_in   = 1'b1;
            end
         end
      end

      rsp_in.dma_busy = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff     <= '0;
         page_ff    <= 8'h00;
         index_ff   <= 8'h00;
         byte_ff    <= 8'h00;
         running_ff <= 1'b0;
         align_ff   <= 1'b1;
         phase_ff   <= 3'd0;
      end else if (cmd.commit) begin
         pad_ff     <= pad_in;
         page_ff    <= page_in;
         index_ff   <= index_in;
         byte_ff    <= byte_in;
         running_ff <= running_in;
         align_ff   <= align_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

FILE: design/console_cpu_bus_with_sprite_dma_top.sv
// ---------------------------------------------------------------------------
// console_cpu_bus_with_sprite_dma_top
// CPU bus decode of a game console with controller ports and sprite DMA.
// ---------------------------------------------------------------------------
// Items arrive on req_bus: a bus read, a bus write or one master clock tick.
// Every item produces exactly one result on rsp_bus, in order.
// An item accepted at edge N reads work RAM and the program store at that
// edge; once the output register is free, the result is formed and loaded
// into it, and rsp_bus.valid rises with that load. The sequencer takes the
// next item only after the result is loaded, so a new item is not accepted
// before the result of the last one is in the output register.
// If the receiver stalls, the held result stays in the output register and
// one more item is accepted and parked until the register frees.
// Reset (synchronous) clears the sequencer, result valid, the controller
// shift registers, DMA page/index/byte, DMA active, the tick phase, and
// re-arms the DMA alignment wait. Work RAM and program store keep their
// contents across reset.
// ---------------------------------------------------------------------------
module console_cpu_bus_with_sprite_dma_top #(
   parameter int RAM_BYTES     = ccbsd_pkg::RAM_BYTES_DEF,
   parameter int PROGRAM_BYTES = ccbsd_pkg::PROGRAM_BYTES_DEF
) (
   input logic           clock,
   input logic           reset,
   ccbsd_req_if.sink     req_bus,
   ccbsd_rsp_if.source   rsp_bus
);

   ccbsd_pkg::ctrl_cmd_type    cmd;
   ccbsd_pkg::req_payload_type req;
   ccbsd_pkg::rsp_payload_type rsp;
   logic                       req_ready;
   logic                       rsp_valid;

   assign req.mode               = req_bus.mode;
   assign req.address            = req_bus.address;
   assign req.write_data         = req_bus.write_data;
   assign req.ppu_read_data      = req_bus.ppu_read_data;
   assign req.controller_buttons = req_bus.controller_buttons;
   assign req.ppu_nmi            = req_bus.ppu_nmi;

   ccbsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   ccbsd_datapath #(
      .RAM_BYTES     (RAM_BYTES),
      .PROGRAM_BYTES (PROGRAM_BYTES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req),
      .rsp   (rsp)
   );

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.read_data    = rsp.read_data;
   assign rsp_bus.ppu_access   = rsp.ppu_access;
   assign rsp_bus.ppu_write    = rsp.ppu_write;
   assign rsp_bus.ppu_register = rsp.ppu_register;
   assign rsp_bus.oam_write    = rsp.oam_write;
   assign rsp_bus.oam_index    = rsp.oam_index;
   assign rsp_bus.oam_data     = rsp.oam_data;
   assign rsp_bus.cpu_step     = rsp.cpu_step;
   assign rsp_bus.cpu_nmi      = rsp.cpu_nmi;
   assign rsp_bus.dma_busy     = rsp.dma_busy;

endmodule

FILE: design/ccbsd_checker.sv
// ---------------------------------------------------------------------------
// ccbsd_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "console_cpu_bus_with_sprite_dma_top_macros.svh"

module ccbsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] read_data,
   input logic       ppu_write,
   input logic       oam_write,
   input logic       cpu_step,
   input logic       cpu_nmi,
   input logic       dma_busy
);

   `CCBSD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `CCBSD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")
   `CCBSD_ASSERT(a_oam_no_step, clock, reset, rsp_valid && oam_write |-> !cpu_step && !ppu_write, "sprite write overlaps cpu step")
   `CCBSD_ASSERT(a_step_idle_dma, clock, reset, rsp_valid && cpu_step |-> !dma_busy, "cpu step while dma busy")
   `CCBSD_ASSERT(a_write_no_data, clock, reset, rsp_valid && ppu_write |-> read_data == 8'h00 && !cpu_nmi, "ppu write carries read data")

endmodule

bind console_cpu_bus_with_sprite_dma_top ccbsd_checker u_ccbsd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .read_data (rsp_bus.read_data),
   .ppu_write (rsp_bus.ppu_write),
   .oam_write (rsp_bus.oam_write),
   .cpu_step  (rsp_bus.cpu_step),
   .cpu_nmi   (rsp_bus.cpu_nmi),
   .dma_busy  (rsp_bus.dma_busy)
);

FILE: tb/sv/console_cpu_bus_with_sprite_dma_top_test.sv
// ---------------------------------------------------------------------------
// console_cpu_bus_with_sprite_dma_top_test
// Drives bus reads, bus writes and master ticks into the console CPU bus and
// checks every result against a cycle-free model of the address decode, the
// controller shift registers, the tick phase and the sprite DMA sequencer.
// ---------------------------------------------------------------------------
module console_cpu_bus_with_sprite_dma_top_test;
   import ccbsd_pkg::*;

   localparam int RAM_SIZE     = RAM_BYTES_DEF;
   localparam int PROG_SIZE    = PROGRAM_BYTES_DEF;
   localparam int RAM_WINDOW   = 8192;
   localparam int PROG_WINDOW  = 32768;
   localparam logic [1:0] MODE_IDLE = 2'd3;
   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;

   ccbsd_req_if req_if ();
   ccbsd_rsp_if rsp_if ();

   console_cpu_bus_with_sprite_dma_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // bus model state
   logic [7:0] ram_mem [RAM_SIZE];
   bit         ram_valid [RAM_SIZE];
   int         ram_filled [$];
   logic [7:0] prog_mem [PROG_SIZE];
   bit         prog_valid [PROG_SIZE];
   int         prog_filled [$];
   logic [7:0] pad_reg [2];
   logic [7:0] dma_page;
   logic [7:0] dma_idx;
   logic [7:0] dma_byte;
   logic       dma_run;
   logic       dma_align;
   logic [2:0] tick_phase;

   rsp_payload_type expected_rsp [$];

   int   fail_count    = 0;
   int   item_count    = 0;
   int   cycle_count   = 0;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic hold_rsp;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic int prog_index(logic [15:0] a);
      return int'(16'(a - ADDR_PROG)) % PROG_SIZE;
   endfunction

   function automatic logic [7:0] model_read(logic [15:0] a, logic [7:0] pbyte,
                                             inout rsp_payload_type r);
      logic [7:0] v;
      v = 8'h00;
      if (a <= ADDR_RAM_END) begin
         v = ram_mem[int'(a) % RAM_SIZE];
      end else if (a <= ADDR_PPU_END) begin
         r.ppu_access   = 1'b1;
         r.ppu_write    = 1'b0;
         r.ppu_register = a[2:0];
         v = pbyte;
      end else if (a == ADDR_PAD0 || a == ADDR_PAD1) begin
         v = {7'b0, pad_reg[a[0]][7]};
         pad_reg[a[0]] = pad_reg[a[0]] << 1;
      end else if (a >= ADDR_PROG) begin
         v = prog_mem[prog_index(a)];
      end
      return v;
   endfunction

   function automatic rsp_payload_type predict_bus(req_payload_type it);
      rsp_payload_type r;
      logic [7:0]      rd;
      logic [2:0]      ph;
      int              idx;
      r = '0;
      case (it.mode)
         MODE_READ: begin
            rd = model_read(it.address, it.ppu_read_data, r);
            r.read_data = rd;
         end
         MODE_WRITE: begin
            if (it.address <= ADDR_RAM_END) begin
               idx = int'(it.address) % RAM_SIZE;
               ram_mem[idx] = it.write_data;
               if (!ram_valid[idx]) ram_filled.push_back(idx);
               ram_valid[idx] = 1'b1;
            end else if (it.address <= ADDR_PPU_END) begin
               r.ppu_access   = 1'b1;
               r.ppu_write    = 1'b1;
               r.ppu_register = it.address[2:0];
            end else if (it.address == ADDR_DMA_PAGE) begin
               dma_page = it.write_data;
               dma_idx  = 8'h00;
               dma_run  = 1'b1;
            end else if (it.address == ADDR_PAD0 || it.address == ADDR_PAD1) begin
               pad_reg[it.address[0]] = it.controller_buttons;
            end else if (it.address >= ADDR_PROG) begin
               idx = prog_index(it.address);
               prog_mem[idx] = it.write_data;
               if (!prog_valid[idx]) prog_filled.push_back(idx);
               prog_valid[idx] = 1'b1;
            end
         end
         MODE_TICK: begin
            ph = tick_phase;
            if (ph == PHASE_SLOT_A || ph == PHASE_SLOT_B) begin
               if (!dma_run) begin
                  r.cpu_step = 1'b1;
               end else if (dma_align) begin
                  if (ph == PHASE_SLOT_B) dma_align = 1'b0;
               end else if (ph == PHASE_SLOT_A) begin
                  dma_byte = model_read({dma_page, dma_idx}, it.ppu_read_data, r);
               end else begin
                  r.oam_write = 1'b1;
                  r.oam_index = dma_idx;
                  r.oam_data  = dma_byte;
                  if (dma_idx == DMA_LAST_INDEX) begin
                     dma_run   = 1'b0;
                     dma_align = 1'b1;
                  end
                  dma_idx = dma_idx + 8'd1;
               end
            end
            tick_phase = (ph >= PHASE_LAST) ? 3'd0 : ph + 3'd1;
            r.cpu_nmi = it.ppu_nmi;
         end
         default: begin
         end
      endcase
      r.dma_busy = dma_run;
      return r;
   endfunction

   // a DMA source page may only be used once every stored byte in it is known
   function automatic bit page_ready(logic [7:0] page);
      logic [15:0] a;
      bit          ok;
      ok = 1'b1;
      for (int i = 0; i < 256; i++) begin
         a = {page, 8'(i)};
         if (a <= ADDR_RAM_END && !ram_valid[int'(a) % RAM_SIZE]) ok = 1'b0;
         if (a >= ADDR_PROG && !prog_valid[prog_index(a)]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [7:0] pick_dma_page();
      logic [7:0] p;
      repeat (8) begin
         p = 8'($urandom);
         if (page_ready(p)) return p;
      end
      return 8'($urandom_range(8'h20, 8'h7F));
   endfunction

   function automatic logic [15:0] pick_open_addr();
      logic [15:0] a;
      a = 16'($urandom_range(16'h4000, 16'h7FFF));
      if (a == ADDR_DMA_PAGE) a = 16'h4015;
      return a;
   endfunction

   function automatic logic [15:0] pick_read_addr();
      int          sel;
      int          idx;
      logic [15:0] a;
      sel = $urandom_range(2);
      if (sel == 0 && ram_filled.size() > 0) begin
         idx = ram_filled[$urandom_range(ram_filled.size() - 1)];
         a = 16'(idx + RAM_SIZE * int'($urandom_range(RAM_WINDOW / RAM_SIZE - 1)));
      end else if (sel == 1 && prog_filled.size() > 0) begin
         idx = prog_filled[$urandom_range(prog_filled.size() - 1)];
         a = 16'(int'(ADDR_PROG) + idx
                 + PROG_SIZE * int'($urandom_range(PROG_WINDOW / PROG_SIZE - 1)));
      end else begin
         a = pick_open_addr();
      end
      return a;
   endfunction

   task automatic send_item(logic [1:0] mode, logic [15:0] addr, logic [7:0] wdata);
      req_payload_type it;
      it.mode               = mode;
      it.address            = addr;
      it.write_data         = wdata;
      it.ppu_read_data      = 8'($urandom);
      it.controller_buttons = 8'($urandom);
      it.ppu_nmi            = 1'($urandom);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid              <= 1'b1;
      req_if.mode               <= it.mode;
      req_if.address            <= it.address;
      req_if.write_data         <= it.write_data;
      req_if.ppu_read_data      <= it.ppu_read_data;
      req_if.controller_buttons <= it.controller_buttons;
      req_if.ppu_nmi            <= it.ppu_nmi;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_rsp.push_back(predict_bus(it));
      if (mode != MODE_IDLE) item_count++;
   endtask

   task automatic dma_tick_or_access();
      if ($urandom_range(9) == 0) begin
         send_item(MODE_READ, pick_read_addr(), 8'($urandom));
      end else begin
         send_item(MODE_TICK, 16'($urandom), 8'($urandom));
      end
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            $error("result transfer with no item outstanding, read_data 0x%0h",
                   rsp_if.read_data);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("read_data",    want.read_data,    rsp_if.read_data);
            check_field("ppu_access",   want.ppu_access,   rsp_if.ppu_access);
            check_field("ppu_write",    want.ppu_write,    rsp_if.ppu_write);
            check_field("ppu_register", want.ppu_register, rsp_if.ppu_register);
            check_field("oam_write",    want.oam_write,    rsp_if.oam_write);
            check_field("oam_index",    want.oam_index,    rsp_if.oam_index);
            check_field("oam_data",     want.oam_data,     rsp_if.oam_data);
            check_field("cpu_step",     want.cpu_step,     rsp_if.cpu_step);
            check_field("cpu_nmi",      want.cpu_nmi,      rsp_if.cpu_nmi);
            check_field("dma_busy",     want.dma_busy,     rsp_if.dma_busy);
         end
      end
   end

   task automatic test_bus_decode();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_item(MODE_WRITE, 16'h0000, 8'h00);
      send_item(MODE_WRITE, 16'h07FF, 8'hFF);
      send_item(MODE_READ,  16'h1800, 8'h00);
      send_item(MODE_READ,  16'h1FFF, 8'h00);
      send_item(MODE_WRITE, 16'h2000, 8'h5A);
      send_item(MODE_READ,  ADDR_PPU_END, 8'h00);
      send_item(MODE_READ,  ADDR_PAD0, 8'h00);
      send_item(MODE_WRITE, ADDR_PAD0, 8'h00);
      repeat (3) send_item(MODE_READ, ADDR_PAD0, 8'h00);
      send_item(MODE_WRITE, ADDR_PAD1, 8'hFF);
      send_item(MODE_READ,  ADDR_PAD1, 8'h00);
      send_item(MODE_WRITE, 16'h4015, 8'hFF);
      send_item(MODE_READ,  16'h7FFF, 8'h00);
      send_item(MODE_WRITE, ADDR_PROG, 8'hA5);
      send_item(MODE_READ,  16'hC000, 8'h00);
      send_item(MODE_WRITE, 16'hFFFF, 8'h3C);
      send_item(MODE_READ,  16'hBFFF, 8'h00);
      send_item(MODE_IDLE,  16'hFFFF, 8'hFF);
   endtask

   task automatic test_tick_phases();
      send_idle_pct = 0;
      stall_pct     = 50;
      repeat (7) send_item(MODE_TICK, 16'($urandom), 8'($urandom));
   endtask

   // restarts through pad, PPU, program and RAM source pages, last one to the end
   task automatic test_sprite_dma();
      send_idle_pct = 37;
      stall_pct     = 37;
      for (int i = 0; i < 256; i++) begin
         send_item(MODE_WRITE, 16'(16'h0300 + i + RAM_SIZE * int'($urandom_range(3))),
                   8'($urandom));
      end
      for (int i = 0; i < 256; i++) begin
         send_item(MODE_WRITE, 16'(16'hC500 + i), 8'($urandom));
      end
      send_item(MODE_WRITE, ADDR_PAD0, 8'h00);
      send_item(MODE_WRITE, ADDR_PAD1, 8'h00);
      send_item(MODE_WRITE, ADDR_DMA_PAGE, 8'h40);
      repeat (200) dma_tick_or_access();
      send_item(MODE_WRITE, ADDR_DMA_PAGE, 8'h2A);
      repeat (100) dma_tick_or_access();
      send_item(MODE_WRITE, ADDR_DMA_PAGE, 8'h85);
      repeat (300) dma_tick_or_access();
      send_item(MODE_WRITE, ADDR_DMA_PAGE, 8'h0B);
      while (dma_run) dma_tick_or_access();
      repeat (8) send_item(MODE_TICK, 16'($urandom), 8'($urandom));
   endtask

   task automatic test_random_traffic();
      int start;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         start = item_count;
         while (item_count - start < RANDOM_ITEMS / 4) begin
            int          pick;
            logic [15:0] a;
            pick = $urandom_range(99);
            if (pick < 40) begin
               repeat ($urandom_range(1, 12)) send_item(MODE_TICK, 16'($urandom), 8'($urandom));
            end else if (pick < 55) begin
               send_item(MODE_WRITE, 16'($urandom_range(0, ADDR_RAM_END)), 8'($urandom));
            end else if (pick < 67) begin
               send_item(MODE_READ, pick_read_addr(), 8'($urandom));
            end else if (pick < 75) begin
               send_item(MODE_WRITE, 16'($urandom_range(ADDR_PROG, 16'hFFFF)), 8'($urandom));
            end else if (pick < 83) begin
               send_item($urandom_range(1) ? MODE_WRITE : MODE_READ,
                         16'($urandom_range(16'h2000, ADDR_PPU_END)), 8'($urandom));
            end else if (pick < 89) begin
               a = $urandom_range(1) ? ADDR_PAD1 : ADDR_PAD0;
               send_item(MODE_WRITE, a, 8'($urandom));
               repeat ($urandom_range(1, 9)) send_item(MODE_READ, a, 8'($urandom));
            end else if (pick < 94) begin
               send_item(MODE_WRITE, ADDR_DMA_PAGE, pick_dma_page());
            end else if (pick < 97) begin
               send_item($urandom_range(1) ? MODE_WRITE : MODE_READ, pick_open_addr(),
                         8'($urandom));
            end else begin
               send_item(MODE_IDLE, 16'($urandom), 8'($urandom));
            end
         end
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      repeat (24) dma_tick_or_access();
   endtask

   initial begin
      reset                     = 1'b1;
      hold_rsp                  = 1'b0;
      rsp_if.ready              = 1'b0;
      req_if.valid              = 1'b0;
      req_if.mode               = MODE_READ;
      req_if.address            = 16'h0000;
      req_if.write_data         = 8'h00;
      req_if.ppu_read_data      = 8'h00;
      req_if.controller_buttons = 8'h00;
      req_if.ppu_nmi            = 1'b0;
      pad_reg[0] = 8'h00;
      pad_reg[1] = 8'h00;
      dma_page   = 8'h00;
      dma_idx    = 8'h00;
      dma_byte   = 8'h00;
      dma_run    = 1'b0;
      dma_align  = 1'b1;
      tick_phase = 3'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_bus_decode();
      test_tick_phases();
      test_sprite_dma();
      test_random_traffic();
      test_backpressure();

      req_if.valid <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
